@@ design/srg_pkg.sv @@
// shared constants, types and register codes of the sorted reading range grouper
package srg_pkg;

    localparam int MAX_READINGS     = 32;
    localparam int READING_BITS     = 12;
    localparam int CFG_BITS         = 12;
    localparam int GROUP_COUNT_BITS = 6;
    localparam int CFG_INDEX_W      = 2;

    localparam int COUNT_W     = $clog2(MAX_READINGS + 1);
    localparam int CNT_EXT_W   = (COUNT_W > GROUP_COUNT_BITS) ? COUNT_W : GROUP_COUNT_BITS;
    localparam int CMP_W       = (READING_BITS > CFG_BITS) ? READING_BITS : CFG_BITS;
    localparam int IN_TDATA_W  = ((2 * READING_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_W = 2 * READING_BITS + GROUP_COUNT_BITS + 3;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    typedef logic [READING_BITS-1:0] reading_t;
    typedef logic [CFG_BITS-1:0]     cfg_t;
    typedef logic [COUNT_W-1:0]      count_t;
    typedef logic [CFG_INDEX_W-1:0]  cfg_index_t;

    localparam cfg_index_t CFG_CURRENT_LIMIT  = 2'd0;
    localparam cfg_index_t CFG_PAIR_TOLERANCE = 2'd1;
    localparam cfg_index_t CFG_GROUP_SPACING  = 2'd2;

    localparam cfg_t CURRENT_LIMIT_RESET  = 12'd240;
    localparam cfg_t PAIR_TOLERANCE_RESET = 12'd8;
    localparam cfg_t GROUP_SPACING_RESET  = 12'd24;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic     insert;
        logic     shift;
        reading_t value;
    } cell_ctrl_t;

    typedef struct packed {
        logic over_limit;
        logic pair_mismatch;
        logic overflow;
    } batch_flags_t;

    typedef struct packed {
        logic busy;
        logic pop;
        logic done;
    } scan_status_t;

endpackage

@@ design/srg_cell.sv @@
// one cell of the insertion sort chain
module srg_cell (
    input  logic              clk,
    input  srg_pkg::cell_ctrl_t ctrl,
    input  logic              valid,
    input  srg_pkg::reading_t left_value,
    input  logic              left_key,
    input  srg_pkg::reading_t right_value,
    output srg_pkg::reading_t value,
    output logic              key
);
    import srg_pkg::*;

    reading_t value_reg;
    reading_t value_next;

    // an empty cell acts as holding an infinite value
    assign key   = !valid || (value_reg > ctrl.value);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.insert)
        begin
            if (left_key)
                value_next = left_value;
            else if (key)
                value_next = ctrl.value;
        end
        else if (ctrl.shift)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

@@ design/srg_scan.sv @@
// group scanner over the chain head and the result output register
module srg_scan (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  srg_pkg::reading_t     head,
    input  logic                  last_entry,
    input  srg_pkg::cfg_t         spacing,
    input  srg_pkg::batch_flags_t flags,
    input  logic                  m_axis_tready,
    output srg_pkg::scan_status_t status,
    output logic                  m_axis_tvalid,
    output logic [srg_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast
);
    import srg_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FINAL = 3'b100
    } scan_state_t;

    scan_state_t state_reg, state_next;
    logic        first_reg, first_next;
    reading_t    lo_reg, lo_next;
    reading_t    prev_reg, prev_next;
    count_t      cnt_reg, cnt_next;

    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                   out_last_reg, out_last_next;

    logic     can_emit;
    logic     brk;
    reading_t step;
    logic     pop;
    logic     done;
    logic     load;
    logic     load_last;
    logic [CNT_EXT_W-1:0] cnt_ext;

    assign can_emit = !out_valid_reg || m_axis_tready;
    assign step     = head - prev_reg;
    assign brk      = CMP_W'(step) >= CMP_W'(spacing);
    assign cnt_ext  = CNT_EXT_W'(cnt_reg);

    always_comb
    begin
        state_next = state_reg;
        first_next = first_reg;
        lo_next    = lo_reg;
        prev_next  = prev_reg;
        cnt_next   = cnt_reg;
        pop        = 1'b0;
        done       = 1'b0;
        load       = 1'b0;
        load_last  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                    first_next = 1'b1;
                end
            end
            ST_SCAN:
            begin
                if (first_reg)
                begin
                    lo_next    = head;
                    prev_next  = head;
                    cnt_next   = count_t'(1);
                    first_next = 1'b0;
                    pop        = 1'b1;
                end
                else if (brk)
                begin
                    if (can_emit)
                    begin
                        load      = 1'b1;
                        lo_next   = head;
                        prev_next = head;
                        cnt_next  = count_t'(1);
                        pop       = 1'b1;
                    end
                end
                else
                begin
                    cnt_next  = cnt_reg + count_t'(1);
                    prev_next = head;
                    pop       = 1'b1;
                end
                if (pop && last_entry)
                    state_next = ST_FINAL;
            end
            ST_FINAL:
            begin
                if (can_emit)
                begin
                    load       = 1'b1;
                    load_last  = 1'b1;
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_last_next  = load_last;
            out_data_next  = OUT_TDATA_W'({flags.overflow, flags.pair_mismatch,
                                           flags.over_limit,
                                           cnt_ext[GROUP_COUNT_BITS-1:0],
                                           prev_reg, lo_reg});
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        prev_reg     <= prev_next;
        cnt_reg      <= cnt_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign status.busy   = (state_reg != ST_IDLE);
    assign status.pop    = pop;
    assign status.done   = done;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

@@ design/sorted_reading_range_grouper.sv @@
// top level of the sorted reading range grouper: sort chain, batch flags, group scanner
//
//  channel   direction  handshake                  payload
//  s_axis    in         s_axis_tvalid/tready       tdata: reading, partner_reading; tlast
//  m_axis    out        m_axis_tvalid/tready       tdata: low, high, count, flags; tlast
//  cfg       in         cfg_valid/cfg_ready        cfg_index, cfg_data
//
//  readings enter at one item per cycle while the scan is idle; each accepted reading is
//  registered into its sorted place in the chain; after the batch end item the scan pops one
//  reading from the chain head per cycle, holding at a group break while a result is stalled
//  on m_axis_tready; results only wait in the output register, and input resumes with the
//  final group; reset clears the fill count, the batch flags and the handshakes and loads
//  the register defaults; the chain contents stay unset and only filled cells are ever read
module sorted_reading_range_grouper (
    input  logic                             clk,
    input  logic                             rst_n,
    // reading (low bits), partner_reading
    input  logic [srg_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tlast,
    output logic                             s_axis_tready,
    // range_low (low bits), range_high, group_count, over_limit, pair_mismatch, overflow
    output logic [srg_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tvalid,
    output logic                             m_axis_tlast,
    input  logic                             m_axis_tready,
    input  logic                             cfg_valid,
    input  srg_pkg::cfg_index_t              cfg_index,
    input  srg_pkg::cfg_t                    cfg_data,
    output logic                             cfg_ready
);
    import srg_pkg::*;

    // configuration registers
    cfg_t limit_reg, limit_next;
    cfg_t tol_reg, tol_next;
    cfg_t spacing_reg, spacing_next;

    // batch state
    count_t       count_reg, count_next;
    batch_flags_t flags_reg, flags_next;

    logic         accept;
    logic         full;
    reading_t     reading;
    reading_t     partner;
    reading_t     pair_diff;
    cell_ctrl_t   ctrl;
    scan_status_t status;

    reading_t cell_value [MAX_READINGS];
    logic     cell_key   [MAX_READINGS];
    logic     cell_valid [MAX_READINGS];
    reading_t left_value [MAX_READINGS];
    logic     left_key   [MAX_READINGS];
    reading_t right_value[MAX_READINGS];

    assign s_axis_tready = !status.busy;
    assign cfg_ready     = 1'b1;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign reading       = s_axis_tdata[READING_BITS-1:0];
    assign partner       = s_axis_tdata[2*READING_BITS-1:READING_BITS];
    assign pair_diff     = (reading >= partner) ? (reading - partner) : (partner - reading);
    assign full          = (count_reg == count_t'(MAX_READINGS));

    // the chain inserts while filling and shifts toward the head while scanning
    assign ctrl.insert = accept && !full;
    assign ctrl.shift  = status.pop;
    assign ctrl.value  = reading;

    genvar g;
    generate
        for (g = 0; g < MAX_READINGS; g++)
        begin : g_chain
            assign cell_valid[g] = (count_t'(g) < count_reg);

            if (g == 0)
            begin : g_head
                assign left_value[g] = '0;
                assign left_key[g]   = 1'b0;
            end
            else
            begin : g_body
                assign left_value[g] = cell_value[g-1];
                assign left_key[g]   = cell_key[g-1];
            end

            if (g == MAX_READINGS - 1)
            begin : g_tail
                assign right_value[g] = '0;
            end
            else
            begin : g_inner
                assign right_value[g] = cell_value[g+1];
            end

            srg_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .valid       (cell_valid[g]),
                .left_value  (left_value[g]),
                .left_key    (left_key[g]),
                .right_value (right_value[g]),
                .value       (cell_value[g]),
                .key         (cell_key[g])
            );
        end
    endgenerate

    // scanner walks the sorted chain from its head once the batch closes
    srg_scan u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (accept && s_axis_tlast),
        .head          (cell_value[0]),
        .last_entry    (count_reg == count_t'(1)),
        .spacing       (spacing_reg),
        .flags         (flags_reg),
        .m_axis_tready (m_axis_tready),
        .status        (status),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always_comb
    begin
        count_next = count_reg;
        flags_next = flags_reg;
        if (accept)
        begin
            if (CMP_W'(reading) >= CMP_W'(limit_reg))
                flags_next.over_limit = 1'b1;
            if (CMP_W'(pair_diff) > CMP_W'(tol_reg))
                flags_next.pair_mismatch = 1'b1;
            // a full store drops the reading but its checks still count
            if (full)
                flags_next.overflow = 1'b1;
            else
                count_next = count_reg + count_t'(1);
        end
        if (status.pop)
            count_next = count_reg - count_t'(1);
        if (status.done)
        begin
            count_next = '0;
            flags_next = '0;
        end
    end

    always_comb
    begin
        limit_next   = limit_reg;
        tol_next     = tol_reg;
        spacing_next = spacing_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CURRENT_LIMIT:  limit_next   = cfg_data;
                CFG_PAIR_TOLERANCE: tol_next     = cfg_data;
                CFG_GROUP_SPACING:  spacing_next = cfg_data;
                default:            limit_next   = limit_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= CURRENT_LIMIT_RESET;
            tol_reg     <= PAIR_TOLERANCE_RESET;
            spacing_reg <= GROUP_SPACING_RESET;
            count_reg   <= '0;
            flags_reg   <= '0;
        end
        else
        begin
            limit_reg   <= limit_next;
            tol_reg     <= tol_next;
            spacing_reg <= spacing_next;
            count_reg   <= count_next;
            flags_reg   <= flags_next;
        end
    end

endmodule

@@ design/srg_checker.sv @@
// port level checks of the sorted reading range grouper and their bind
module srg_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tlast,
    input logic                             s_axis_tready,
    input logic [srg_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tlast,
    input logic                             m_axis_tready
);
    import srg_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // the scan takes over right after the closing item
    a_scan_starts: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input still open after batch end");

    // input reopens only together with the final group of the batch
    a_reopen_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s_axis_tready) |-> m_axis_tvalid && m_axis_tlast)
        else $error("input reopened without final group");

endmodule

bind sorted_reading_range_grouper srg_checker u_srg_checker (.*);

@@ test/tb_sorted_reading_range_grouper.sv @@
// self-checking testbench of the sorted reading range grouper: directed batches, random batches, idling phases
module tb_sorted_reading_range_grouper;
    import srg_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 8;     // scan wind-down after the last group of a batch
    localparam int DRAIN_CYCLES  = 64;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 75;
    localparam int PRINT_CAP     = 20;
    localparam int READING_MAX   = (1 << READING_BITS) - 1;

    // index with no register behind it, writes must be ignored
    localparam cfg_index_t CFG_UNUSED = 2'd3;

    // bit positions of the result fields in m_axis_tdata
    localparam int LOW_LSB   = 0;
    localparam int HIGH_LSB  = READING_BITS;
    localparam int COUNT_LSB = 2 * READING_BITS;
    localparam int FLAG_LSB  = COUNT_LSB + GROUP_COUNT_BITS;

    typedef struct {
        reading_t                    lo;
        reading_t                    hi;
        logic [GROUP_COUNT_BITS-1:0] count;
        logic                        over_limit;
        logic                        pair_mismatch;
        logic                        overflow;
        logic                        last_group;
    } group_result_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    // reading (low bits), partner_reading
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tlast  = 1'b0;
    logic                   s_axis_tready;
    // range_low (low bits), range_high, group_count, over_limit, pair_mismatch, overflow
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tlast;
    logic                   m_axis_tready = 1'b0;
    logic                   cfg_valid     = 1'b0;
    cfg_index_t             cfg_index     = CFG_CURRENT_LIMIT;
    cfg_t                   cfg_data      = '0;
    logic                   cfg_ready;

    // predictor copy of the registers and of the batch state
    cfg_t     shadow_limit   = CURRENT_LIMIT_RESET;
    cfg_t     shadow_tol     = PAIR_TOLERANCE_RESET;
    cfg_t     shadow_spacing = GROUP_SPACING_RESET;
    reading_t sorted_readings [MAX_READINGS];
    int       readings_held  = 0;
    logic     danger_noted   = 1'b0;
    logic     mismatch_noted = 1'b0;
    logic     dropped_noted  = 1'b0;

    group_result_t expected_groups [$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int errors         = 0;
    int items_sent     = 0;
    int batches_sent   = 0;
    int groups_checked = 0;
    int cycle_count    = 0;

    sorted_reading_range_grouper i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tready (m_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cfg_ready     (cfg_ready)
    );

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // watchdog
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("sorted_reading_range_grouper regression: fail");
        $finish;
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        if (errors <= PRINT_CAP)
            $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
    endtask

    task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    function automatic reading_t clamp_reading(int v);
        if (v < 0)
            return '0;
        if (v > READING_MAX)
            return reading_t'(READING_MAX);
        return reading_t'(v);
    endfunction

    task automatic push_group(reading_t lo, reading_t hi, int cnt, logic last);
        group_result_t g;
        g.lo            = lo;
        g.hi            = hi;
        g.count         = cnt[GROUP_COUNT_BITS-1:0];
        g.over_limit    = danger_noted;
        g.pair_mismatch = mismatch_noted;
        g.overflow      = dropped_noted;
        g.last_group    = last;
        expected_groups.insert(expected_groups.size(), g);
    endtask

    // insertion into the sorted copy, flag tracking, and the groups of a closed batch
    task automatic predict_groups(reading_t r, reading_t p, logic batch_end);
        int       diff;
        int       pos;
        int       cnt;
        reading_t lo;
        diff = (r >= p) ? int'(r) - int'(p) : int'(p) - int'(r);
        if (r >= shadow_limit)
            danger_noted = 1'b1;
        if (diff > int'(shadow_tol))
            mismatch_noted = 1'b1;
        if (readings_held < MAX_READINGS)
        begin
            pos = readings_held;
            while (pos > 0 && sorted_readings[pos-1] > r)
            begin
                sorted_readings[pos] = sorted_readings[pos-1];
                pos--;
            end
            sorted_readings[pos] = r;
            readings_held++;
        end
        else
        begin
            dropped_noted = 1'b1;
        end
        if (batch_end)
        begin
            lo  = sorted_readings[0];
            cnt = 1;
            for (int i = 1; i < readings_held; i++)
            begin
                if (int'(sorted_readings[i]) - int'(sorted_readings[i-1]) >= int'(shadow_spacing))
                begin
                    push_group(lo, sorted_readings[i-1], cnt, 1'b0);
                    lo  = sorted_readings[i];
                    cnt = 1;
                end
                else
                begin
                    cnt++;
                end
            end
            push_group(lo, sorted_readings[readings_held-1], cnt, 1'b1);
            readings_held  = 0;
            danger_noted   = 1'b0;
            mismatch_noted = 1'b0;
            dropped_noted  = 1'b0;
        end
    endtask

    // every accepted group is matched against the oldest prediction
    always @(posedge clk)
    begin : check_groups
        group_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            groups_checked++;
            if (expected_groups.size() == 0)
            begin
                report_mismatch("group with nothing expected, range_low",
                                32'(m_axis_tdata[LOW_LSB +: READING_BITS]), 0);
            end
            else
            begin
                want = expected_groups.pop_front();
                check_field("range_low", 32'(m_axis_tdata[LOW_LSB +: READING_BITS]),
                            32'(want.lo));
                check_field("range_high", 32'(m_axis_tdata[HIGH_LSB +: READING_BITS]),
                            32'(want.hi));
                check_field("group_count", 32'(m_axis_tdata[COUNT_LSB +: GROUP_COUNT_BITS]),
                            32'(want.count));
                check_field("over_limit", 32'(m_axis_tdata[FLAG_LSB]), 32'(want.over_limit));
                check_field("pair_mismatch", 32'(m_axis_tdata[FLAG_LSB+1]),
                            32'(want.pair_mismatch));
                check_field("overflow", 32'(m_axis_tdata[FLAG_LSB+2]), 32'(want.overflow));
                check_field("last_group", 32'(m_axis_tlast), 32'(want.last_group));
            end
        end
    end

    // one reading item, with a random idle gap ahead of it
    task automatic send_reading(reading_t r, reading_t p, logic batch_end);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {p, r};
        s_axis_tlast  <= batch_end;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_groups(r, p, batch_end);
        items_sent++;
        if (batch_end)
            batches_sent++;
    endtask

    // all groups in, then let the scan settle so the block is idle
    task automatic wait_for_results();
        while (expected_groups.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // cfg_valid stays high between back-to-back writes; the caller lowers it
    task automatic write_reg(cfg_index_t idx, cfg_t value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_CURRENT_LIMIT:  shadow_limit   = value;
            CFG_PAIR_TOLERANCE: shadow_tol     = value;
            CFG_GROUP_SPACING:  shadow_spacing = value;
            default: ;
        endcase
    endtask

    task automatic program_registers(cfg_t lim, cfg_t tol, cfg_t spc, logic poke_unused);
        wait_for_results();
        if (poke_unused)
            write_reg(CFG_UNUSED, '1);
        write_reg(CFG_CURRENT_LIMIT, lim);
        write_reg(CFG_PAIR_TOLERANCE, tol);
        write_reg(CFG_GROUP_SPACING, spc);
        cfg_valid <= 1'b0;
    endtask

    // values near the typical use as often as values from the full range, with both extremes mixed in
    function automatic cfg_t pick_setting(int typical_max);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return cfg_t'($urandom_range(0, typical_max));
            default: return cfg_t'($urandom_range(0, READING_MAX));
        endcase
    endfunction

    // readings clustered around a base, partners near the tolerance edge
    task automatic send_random_batch(int len);
        int       base;
        int       spread;
        int       band;
        reading_t r;
        reading_t p;
        base   = $urandom_range(0, READING_MAX);
        spread = ($urandom_range(0, 3) == 0) ? 2 * READING_MAX : $urandom_range(0, 200);
        band   = (int'(shadow_tol) + 2 > 200) ? 200 : int'(shadow_tol) + 2;
        for (int k = 0; k < len; k++)
        begin
            r = clamp_reading(base + $urandom_range(0, spread) - spread / 2);
            if ($urandom_range(0, 9) == 0)
                p = reading_t'($urandom_range(0, READING_MAX));
            else
                p = clamp_reading(int'(r) + $urandom_range(0, 2 * band) - band);
            send_reading(r, p, k == len - 1);
        end
    endtask

    // reset register values: field extremes, limit and tolerance edges, equal readings,
    // a spacing step exactly at the threshold, a single-reading batch
    task automatic test_reset_defaults();
        send_reading(12'd0, 12'd0, 1'b0);
        send_reading(12'd4095, 12'd0, 1'b0);
        send_reading(12'd4095, 12'd4095, 1'b0);
        send_reading(12'd100, 12'd109, 1'b0);
        send_reading(12'd100, 12'd100, 1'b0);
        send_reading(12'd123, 12'd123, 1'b0);
        send_reading(12'd147, 12'd147, 1'b1);
        // at the limit, pair difference equal to the tolerance
        send_reading(12'd239, 12'd231, 1'b0);
        send_reading(12'd240, 12'd248, 1'b1);
        // lone reading with no flag raised
        send_reading(12'd239, 12'd247, 1'b1);
        s_axis_tvalid <= 1'b0;
    endtask

    // register extremes: spacing zero, all-ones settings with a write to the
    // unused index, and spacing one against equal readings
    task automatic test_register_extremes();
        program_registers('0, '0, '0, 1'b0);
        send_reading(12'd5, 12'd5, 1'b0);
        send_reading(12'd5, 12'd5, 1'b0);
        send_reading(12'd6, 12'd7, 1'b1);
        s_axis_tvalid <= 1'b0;
        program_registers('1, '1, '1, 1'b1);
        send_reading(12'd0, 12'd4095, 1'b0);
        send_reading(12'd4095, 12'd0, 1'b0);
        send_reading(12'd4094, 12'd4094, 1'b1);
        s_axis_tvalid <= 1'b0;
        program_registers('1, '0, 12'd1, 1'b0);
        send_reading(12'd7, 12'd7, 1'b0);
        send_reading(12'd7, 12'd7, 1'b0);
        send_reading(12'd8, 12'd8, 1'b1);
        s_axis_tvalid <= 1'b0;
    endtask

    // four idling phases, each with fresh random registers; every phase opens with a
    // batch longer than the store so readings are dropped, the closing one always among them
    task automatic test_random_phases();
        int start;
        int len;
        for (int phase = 0; phase < 4; phase++)
        begin
            program_registers(pick_setting(READING_MAX), pick_setting(32), pick_setting(64),
                              1'b0);
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 84; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 84; end
                default: begin src_idle_pct = 28; sink_stall_pct = 28; end
            endcase
            start = items_sent;
            send_random_batch($urandom_range(MAX_READINGS + 1, MAX_READINGS + 4));
            while (items_sent - start < PHASE_ITEMS)
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(MAX_READINGS - 2,
                                                                    MAX_READINGS + 8)
                                                  : $urandom_range(1, 8);
                send_random_batch(len);
            end
            s_axis_tvalid <= 1'b0;
            wait_for_results();
        end
        src_idle_pct   = 0;
        sink_stall_pct = 0;
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_register_extremes();
        test_random_phases();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_groups.size() != 0)
            report_mismatch("groups never delivered", 0, expected_groups.size());
        $display("covered %0d readings in %0d batches, %0d groups checked, %0d mismatches",
                 items_sent, batches_sent, groups_checked, errors);
        $display("register extremes, spacing zero, dropped readings and four idling phases run");
        if (errors == 0)
            $display("sorted_reading_range_grouper regression: pass");
        else
            $display("sorted_reading_range_grouper regression: fail");
        $finish;
    end

endmodule

@@ sim.f @@
design/srg_pkg.sv
design/srg_cell.sv
design/srg_scan.sv
design/sorted_reading_range_grouper.sv
design/srg_checker.sv
test/tb_sorted_reading_range_grouper.sv
